FILE: rtl/imac_pkg.sv
// Shared types and constants for the IMU motion activity classifier.
`timescale 1ns / 1ps
package imac_pkg;

    localparam int WINDOW_DEPTH_DEF = 64;

    localparam int ACC_W   = 16;
    localparam int GYRO_W  = 22;
    localparam int GAIN_W  = 16;
    localparam int DB_W    = 21;
    localparam int CFG_W   = 22;
    localparam int CFG_A_W = 3;
    localparam int ANGLE_W = 40;
    localparam int ENTRY_W = 18;
    localparam int STD_W   = 17;
    localparam int DMAG_W  = 18;
    localparam int CLASS_W = 3;
    localparam int CNT_W   = 8;

    localparam logic [CFG_A_W-1:0] REG_ACC_OFF_X  = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_ACC_OFF_Y  = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_ACC_OFF_Z  = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_GYRO_OFF_X = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_GYRO_OFF_Y = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_GYRO_OFF_Z = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_ANGLE_GAIN = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_DEADBAND   = 3'd7;

    localparam logic [GAIN_W-1:0] ANGLE_GAIN_RST = 16'd66;
    localparam logic [DB_W-1:0]   DEADBAND_RST   = 21'd50;

    localparam logic [DMAG_W-1:0] STAND_LIMIT = 18'd100;
    localparam logic [DMAG_W-1:0] WALK_LIMIT  = 18'd1000;
    localparam logic [CNT_W-1:0]  HIGH_RUN    = 8'd5;
    localparam logic [CNT_W-1:0]  CNT_MAX     = 8'd255;

    localparam logic [CLASS_W-1:0] CLS_NONE  = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_STAND = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_WALK  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_RUN   = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_JUMP  = 3'd4;

    typedef struct packed {
        logic                       start;
        logic signed [ENTRY_W-1:0]  new_val;
        logic signed [ENTRY_W-1:0]  old_val;
    } lane_cmd_t;

endpackage

FILE: rtl/imu_motion_activity_classifier_unit.sv
// Top level: sample correction, window store, angle integration, classifier.
// Latency is set by two chained bit-serial square roots. One item in flight; the next
// is taken while the previous result waits at the output.
// Reset: asynchronous; then a clearing pass zeroes the window
// RAM, during which no item is taken (configuration writes are taken as ever).
`timescale 1ns / 1ps
module imu_motion_activity_classifier_unit #(
    parameter int WINDOW_DEPTH = imac_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [imac_pkg::CFG_A_W-1:0]          cfg_addr,
    input  logic [imac_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [imac_pkg::ACC_W-1:0]     acc_x,
    input  logic signed [imac_pkg::ACC_W-1:0]     acc_y,
    input  logic signed [imac_pkg::ACC_W-1:0]     acc_z,
    input  logic signed [imac_pkg::GYRO_W-1:0]    gyro_x,
    input  logic signed [imac_pkg::GYRO_W-1:0]    gyro_y,
    input  logic signed [imac_pkg::GYRO_W-1:0]    gyro_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [imac_pkg::CLASS_W-1:0]          motion_class,
    output logic [imac_pkg::DMAG_W-1:0]           diff_magnitude,
    output logic [imac_pkg::STD_W-1:0]            std_x,
    output logic [imac_pkg::STD_W-1:0]            std_y,
    output logic [imac_pkg::STD_W-1:0]            std_z,
    output logic [imac_pkg::STD_W-1:0]            std_magnitude,
    output logic signed [imac_pkg::ANGLE_W-1:0]   angle_x,
    output logic signed [imac_pkg::ANGLE_W-1:0]   angle_y,
    output logic signed [imac_pkg::ANGLE_W-1:0]   angle_z
);
    import imac_pkg::*;

    localparam int PW     = $clog2(WINDOW_DEPTH);
    localparam int WORD_W = 4 * ENTRY_W;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CORR, S_SQ, S_SUM, S_ROOT, S_WIN, S_LANE, S_OUT
    } state_t;

    state_t                     state_reg;
    logic [PW-1:0]              clr_reg;
    logic [PW-1:0]              wp_reg;

    logic signed [ACC_W-1:0]    acc_off_reg [3];
    logic signed [GYRO_W-1:0]   gyro_off_reg [3];
    logic [GAIN_W-1:0]          gain_reg;
    logic [DB_W-1:0]            db_reg;

    logic signed [ACC_W-1:0]    acc_in_reg [3];
    logic signed [GYRO_W-1:0]   gyro_in_reg [3];
    logic signed [ACC_W:0]      c_reg [3];
    logic signed [ENTRY_W-1:0]  d_reg [3];
    logic signed [GYRO_W:0]     g_reg [3];
    logic signed [ACC_W:0]      prev_acc_reg [3];
    logic signed [GYRO_W:0]     prev_gyro_reg [3];
    logic [32:0]                csq_reg [3];
    logic [34:0]                dsq_reg [3];
    logic signed [40:0]         p_reg [3];
    logic                       integ_reg [3];
    logic signed [ANGLE_W-1:0]  angle_reg [3];

    logic [CLASS_W-1:0]         class_reg;
    logic                       high_active_reg;
    logic [CNT_W-1:0]           high_count_reg;
    logic [DMAG_W-1:0]          dmag_reg;

    logic                       out_valid_reg;
    logic [CLASS_W-1:0]         o_class_reg;
    logic [DMAG_W-1:0]          o_dmag_reg;
    logic [STD_W-1:0]           o_std_reg [4];
    logic signed [ANGLE_W-1:0]  o_angle_reg [3];

    logic signed [ACC_W:0]      c_next [3];
    logic signed [ENTRY_W-1:0]  d_next [3];
    logic signed [GYRO_W:0]     g_next [3];
    logic signed [33:0]         csq_prod [3];
    logic signed [35:0]         dsq_prod [3];
    logic signed [GYRO_W+1:0]   s_val [3];
    logic signed [40:0]         p_prod [3];
    logic [GYRO_W:0]            g_abs [3];
    logic [35:0]                msum;
    logic [35:0]                dsum;
    logic                       sqrt_start;
    logic                       m_done;
    logic                       d_done;
    logic [17:0]                m_root;
    logic [17:0]                d_root;
    logic                       ram_we;
    logic [PW-1:0]              ram_waddr;
    logic [WORD_W-1:0]          ram_wdata;
    logic [WORD_W-1:0]          ram_rdata;
    logic [WORD_W-1:0]          new_word;
    lane_cmd_t                  lane_cmd [4];
    logic [3:0]                 lane_done;
    logic [STD_W-1:0]           lane_std [4];
    logic                       out_free;

    logic [CLASS_W-1:0]         class_next;
    logic                       high_active_next;
    logic [CNT_W-1:0]           high_count_next;
    logic [CNT_W-1:0]           cnt_sat;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_next[i]   = (ACC_W+1)'(acc_in_reg[i]) - (ACC_W+1)'(acc_off_reg[i]);
            d_next[i]   = ENTRY_W'(c_next[i]) - ENTRY_W'(prev_acc_reg[i]);
            g_next[i]   = (GYRO_W+1)'(gyro_in_reg[i]) - (GYRO_W+1)'(gyro_off_reg[i]);
            csq_prod[i] = 34'(c_reg[i]) * 34'(c_reg[i]);
            dsq_prod[i] = 36'(d_reg[i]) * 36'(d_reg[i]);
            s_val[i]    = (GYRO_W+2)'(g_reg[i]) + (GYRO_W+2)'(prev_gyro_reg[i]);
            p_prod[i]   = 41'(s_val[i]) * 41'(signed'({1'b0, gain_reg}));
            g_abs[i]    = g_reg[i][GYRO_W] ? (GYRO_W+1)'(-g_reg[i]) : g_reg[i];
        end
    end

    assign msum = 36'(csq_reg[0]) + 36'(csq_reg[1]) + 36'(csq_reg[2]);
    assign dsum = 36'(dsq_reg[0]) + 36'(dsq_reg[1]) + 36'(dsq_reg[2]);
    assign sqrt_start = (state_reg == S_SUM);

    imac_isqrt #(.W(36)) u_msqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (msum),
        .done     (m_done),
        .root     (m_root)
    );

    imac_isqrt #(.W(36)) u_dsqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (dsum),
        .done     (d_done),
        .root     (d_root)
    );

    assign new_word  = {m_root, d_reg[2], d_reg[1], d_reg[0]};
    assign ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WIN);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : wp_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : new_word;

    imac_ram #(.WIDTH(WORD_W), .DEPTH(WINDOW_DEPTH)) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        assign lane_cmd[k].start   = (state_reg == S_WIN);
        assign lane_cmd[k].new_val = new_word[k*ENTRY_W +: ENTRY_W];
        assign lane_cmd[k].old_val = ram_rdata[k*ENTRY_W +: ENTRY_W];

        imac_lane #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .cmd     (lane_cmd[k]),
            .done    (lane_done[k]),
            .std_val (lane_std[k])
        );
    end

    // activity classifier on the difference magnitude
    always_comb
    begin
        class_next       = class_reg;
        high_active_next = high_active_reg;
        high_count_next  = high_count_reg;
        cnt_sat          = (high_count_reg == CNT_MAX) ? CNT_MAX : high_count_reg + 1'b1;
        if (d_root < STAND_LIMIT)
        begin
            if (high_active_reg && (high_count_reg > HIGH_RUN))
            begin
                class_next      = CLS_JUMP;
                high_count_next = cnt_sat;
            end
            else
            begin
                class_next       = CLS_STAND;
                high_active_next = 1'b0;
                high_count_next  = '0;
            end
        end
        else if (d_root < WALK_LIMIT)
        begin
            if (high_active_reg && (high_count_reg < HIGH_RUN))
            begin
                class_next      = CLS_JUMP;
                high_count_next = high_count_reg + 1'b1;
            end
            else
            begin
                class_next       = CLS_WALK;
                high_active_next = 1'b0;
                high_count_next  = '0;
            end
        end
        else
        begin
            if (!high_active_reg)
            begin
                high_active_next = 1'b1;
                high_count_next  = '0;
            end
            else
            begin
                high_count_next = cnt_sat;
            end
            if (high_count_next > HIGH_RUN)
            begin
                class_next = CLS_RUN;
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_off_reg[i]   <= '0;
                gyro_off_reg[i]  <= '0;
                prev_acc_reg[i]  <= '0;
                prev_gyro_reg[i] <= '0;
                angle_reg[i]     <= '0;
            end
            gain_reg        <= ANGLE_GAIN_RST;
            db_reg          <= DEADBAND_RST;
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            wp_reg          <= '0;
            class_reg       <= CLS_NONE;
            high_active_reg <= 1'b0;
            high_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_ACC_OFF_X:  acc_off_reg[0]  <= cfg_wdata[ACC_W-1:0];
                    REG_ACC_OFF_Y:  acc_off_reg[1]  <= cfg_wdata[ACC_W-1:0];
                    REG_ACC_OFF_Z:  acc_off_reg[2]  <= cfg_wdata[ACC_W-1:0];
                    REG_GYRO_OFF_X: gyro_off_reg[0] <= cfg_wdata;
                    REG_GYRO_OFF_Y: gyro_off_reg[1] <= cfg_wdata;
                    REG_GYRO_OFF_Z: gyro_off_reg[2] <= cfg_wdata;
                    REG_ANGLE_GAIN: gain_reg        <= cfg_wdata[GAIN_W-1:0];
                    REG_DEADBAND:   db_reg          <= cfg_wdata[DB_W-1:0];
                    default:        gain_reg        <= gain_reg;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == PW'(WINDOW_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        acc_in_reg[0]  <= acc_x;
                        acc_in_reg[1]  <= acc_y;
                        acc_in_reg[2]  <= acc_z;
                        gyro_in_reg[0] <= gyro_x;
                        gyro_in_reg[1] <= gyro_y;
                        gyro_in_reg[2] <= gyro_z;
                        state_reg      <= S_CORR;
                    end
                end
                S_CORR:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        c_reg[i]        <= c_next[i];
                        d_reg[i]        <= d_next[i];
                        g_reg[i]        <= g_next[i];
                        prev_acc_reg[i] <= c_next[i];
                    end
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        csq_reg[i]       <= csq_prod[i][32:0];
                        dsq_reg[i]       <= dsq_prod[i][34:0];
                        p_reg[i]         <= p_prod[i];
                        integ_reg[i]     <= g_abs[i] > (GYRO_W+1)'(db_reg);
                        prev_gyro_reg[i] <= g_reg[i];
                    end
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    // arithmetic shift gives the floor of the scaled step
                    for (int i = 0; i < 3; i++)
                    begin
                        if (integ_reg[i])
                        begin
                            angle_reg[i] <= angle_reg[i] + ANGLE_W'($signed(p_reg[i][40:17]));
                        end
                    end
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (m_done && d_done)
                    begin
                        state_reg <= S_WIN;
                    end
                end
                S_WIN:
                begin
                    wp_reg          <= (wp_reg == PW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    class_reg       <= class_next;
                    high_active_reg <= high_active_next;
                    high_count_reg  <= high_count_next;
                    dmag_reg        <= d_root;
                    state_reg       <= S_LANE;
                end
                S_LANE:
                begin
                    if (&lane_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        o_class_reg   <= class_reg;
                        o_dmag_reg    <= dmag_reg;
                        for (int k = 0; k < 4; k++)
                        begin
                            o_std_reg[k] <= lane_std[k];
                        end
                        for (int i = 0; i < 3; i++)
                        begin
                            o_angle_reg[i] <= angle_reg[i];
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign motion_class   = o_class_reg;
    assign diff_magnitude = o_dmag_reg;
    assign std_x          = o_std_reg[0];
    assign std_y          = o_std_reg[1];
    assign std_z          = o_std_reg[2];
    assign std_magnitude  = o_std_reg[3];
    assign angle_x        = o_angle_reg[0];
    assign angle_y        = o_angle_reg[1];
    assign angle_z        = o_angle_reg[2];

    a_lanes_together: assert property (@(posedge clk) disable iff (!rst_n)
        lane_done == 4'b0000 || lane_done == 4'b1111)
        else $error("window lanes finished apart");

    a_count_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        high_count_reg != '0 |-> high_active_reg)
        else $error("high count set without an active high run");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg <= PW'(WINDOW_DEPTH - 1))
        else $error("window pointer out of range");

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready)
        else $error("item taken during the clearing pass");

endmodule

FILE: rtl/imac_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/imac_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module imac_isqrt #(
    parameter int W = 36
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   radicand,
    output logic           done,
    output logic [W/2-1:0] root
);

    localparam int RW = W / 2;
    localparam int CW = $clog2(RW + 1);

    logic [W-1:0]    x_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CW-1:0]   cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic            ge;
    logic [RW+3:0]   rem_next;

    assign rem_sh   = {rem_reg, x_reg[W-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign ge       = rem_sh >= trial;
    assign rem_next = ge ? rem_sh - trial : rem_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
            cnt_reg  <= CW'(RW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[W-3:0], 2'b00};
            rem_reg  <= rem_next[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
            cnt_reg  <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: rtl/imac_lane.sv
// One window lane: running sums and floor standard deviation.
`timescale 1ns / 1ps
module imac_lane #(
    parameter int WINDOW_DEPTH = imac_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  imac_pkg::lane_cmd_t          cmd,
    output logic                         done,
    output logic [imac_pkg::STD_W-1:0]   std_val
);
    import imac_pkg::*;

    localparam int L      = $clog2(WINDOW_DEPTH);
    localparam int SUM_W  = 19 + L;
    localparam int SQ_W   = 35 + L;
    localparam int XW     = 36 + 2 * L;
    localparam int RW     = XW / 2;
    localparam int SH     = RW + L;
    localparam int MW     = RW + 2;
    localparam int PRW    = RW + MW;
    // ceil(2^SH / depth): exact floor division for any root below 2^RW
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH));

    typedef enum logic [2:0] {
        LS_IDLE, LS_SQ, LS_SUM, LS_PROD, LS_X, LS_ROOT, LS_DIV
    } lstate_t;

    lstate_t                    state_reg;
    logic signed [ENTRY_W-1:0]  new_reg;
    logic signed [ENTRY_W-1:0]  old_reg;
    logic [34:0]                an2_reg;
    logic [34:0]                ao2_reg;
    logic signed [ENTRY_W:0]    diff_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sumsq_reg;
    logic [XW-1:0]              x_reg;
    logic [RW-1:0]              div_src_reg;
    logic [STD_W-1:0]           std_reg;
    logic                       done_reg;

    logic signed [35:0]         an_prod;
    logic signed [35:0]         ao_prod;
    logic signed [XW-1:0]       ss_prod;
    logic [XW-1:0]              nq_prod;
    logic                       sq_start;
    logic                       sq_done;
    logic [RW-1:0]              sq_root;
    logic [PRW-1:0]             div_prod;

    assign an_prod  = 36'(new_reg) * 36'(new_reg);
    assign ao_prod  = 36'(old_reg) * 36'(old_reg);
    assign ss_prod  = XW'(sum_reg) * XW'(sum_reg);
    assign nq_prod  = XW'(sumsq_reg) * XW'(WINDOW_DEPTH);
    assign sq_start = (state_reg == LS_X);
    assign div_prod = PRW'(div_src_reg) * PRW'(RECIP);

    imac_isqrt #(.W(XW)) u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (x_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= LS_IDLE;
            new_reg     <= '0;
            old_reg     <= '0;
            an2_reg     <= '0;
            ao2_reg     <= '0;
            diff_reg    <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            x_reg       <= '0;
            div_src_reg <= '0;
            std_reg     <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                LS_IDLE:
                begin
                    if (cmd.start)
                    begin
                        new_reg   <= cmd.new_val;
                        old_reg   <= cmd.old_val;
                        state_reg <= LS_SQ;
                    end
                end
                LS_SQ:
                begin
                    an2_reg   <= an_prod[34:0];
                    ao2_reg   <= ao_prod[34:0];
                    diff_reg  <= (ENTRY_W+1)'(new_reg) - (ENTRY_W+1)'(old_reg);
                    state_reg <= LS_SUM;
                end
                LS_SUM:
                begin
                    sum_reg   <= sum_reg + SUM_W'(diff_reg);
                    sumsq_reg <= sumsq_reg + SQ_W'(an2_reg) - SQ_W'(ao2_reg);
                    state_reg <= LS_PROD;
                end
                LS_PROD:
                begin
                    x_reg     <= (nq_prod > ss_prod) ? nq_prod - ss_prod : '0;
                    state_reg <= LS_X;
                end
                LS_X:
                begin
                    state_reg <= LS_ROOT;
                end
                LS_ROOT:
                begin
                    if (sq_done)
                    begin
                        div_src_reg <= sq_root;
                        state_reg   <= LS_DIV;
                    end
                end
                LS_DIV:
                begin
                    std_reg   <= STD_W'(div_prod >> SH);
                    done_reg  <= 1'b1;
                    state_reg <= LS_IDLE;
                end
                default:
                begin
                    state_reg <= LS_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign std_val = std_reg;

endmodule

FILE: dv/imac_checker.sv
// Checker for the IMU motion activity classifier: mirrors its math and compares every result.
`timescale 1ns / 1ps
module imac_checker
    import imac_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_A_W-1:0]         cfg_addr,
    input  logic [CFG_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic signed [ACC_W-1:0]    acc_x,
    input  logic signed [ACC_W-1:0]    acc_y,
    input  logic signed [ACC_W-1:0]    acc_z,
    input  logic signed [GYRO_W-1:0]   gyro_x,
    input  logic signed [GYRO_W-1:0]   gyro_y,
    input  logic signed [GYRO_W-1:0]   gyro_z,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [CLASS_W-1:0]         motion_class,
    input  logic [DMAG_W-1:0]          diff_magnitude,
    input  logic [STD_W-1:0]           std_x,
    input  logic [STD_W-1:0]           std_y,
    input  logic [STD_W-1:0]           std_z,
    input  logic [STD_W-1:0]           std_magnitude,
    input  logic signed [ANGLE_W-1:0]  angle_x,
    input  logic signed [ANGLE_W-1:0]  angle_y,
    input  logic signed [ANGLE_W-1:0]  angle_z,
    output int                         fail_count,
    output int                         pending
);
    localparam int DEPTH = WINDOW_DEPTH_DEF;

    typedef struct packed {
        logic [CLASS_W-1:0]        cls;
        logic [DMAG_W-1:0]         dmag;
        logic [3:0][STD_W-1:0]     sd;
        logic [2:0][ANGLE_W-1:0]   ang;
    } motion_result_t;

    motion_result_t sample_results[$];

    longint acc_off[3], gyro_off[3];
    longint unsigned gain, deadband;
    longint last_acc[3], last_gyro[3];
    logic [ANGLE_W-1:0] ang[3];
    longint win[4][DEPTH];
    longint wsum[4];
    longint unsigned wsq[4];
    int wp;
    logic [CLASS_W-1:0] cls;
    bit hi_on;
    int hi_cnt;

    function automatic longint unsigned floor_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint unsigned window_sd(int k);
        longint unsigned a, nq, ss;
        a = abs64(wsum[k]);
        nq = DEPTH * wsq[k];
        ss = a * a;
        return floor_sqrt(nq > ss ? nq - ss : 0) / DEPTH;
    endfunction

    task automatic window_push(int k, longint v);
        longint old;
        old = win[k][wp];
        win[k][wp] = v;
        wsum[k] += v - old;
        wsq[k] = wsq[k] + abs64(v) * abs64(v) - abs64(old) * abs64(old);
    endtask

    task automatic predict_sample(longint ax[3], longint gy[3]);
        longint c, d, g, p, q;
        longint unsigned msq, dsq, dm;
        motion_result_t r;
        msq = 0;
        dsq = 0;
        for (int i = 0; i < 3; i++)
        begin
            c = ax[i] - acc_off[i];
            d = c - last_acc[i];
            last_acc[i] = c;
            msq += abs64(c) * abs64(c);
            dsq += abs64(d) * abs64(d);
            window_push(i, d);
        end
        window_push(3, longint'(floor_sqrt(msq)));
        for (int i = 0; i < 3; i++)
        begin
            g = gy[i] - gyro_off[i];
            if (abs64(g) > deadband)
            begin
                p = (g + last_gyro[i]) * longint'(gain);
                if (p >= 0) q = p >>> 17;
                else q = -longint'((longint'(-p) + 131071) >>> 17);
                ang[i] = ang[i] + q[ANGLE_W-1:0];
            end
            last_gyro[i] = g;
        end
        wp = (wp + 1 >= DEPTH) ? 0 : wp + 1;
        dm = floor_sqrt(dsq);
        if (dm < STAND_LIMIT)
        begin
            if (hi_on && hi_cnt > HIGH_RUN)
            begin
                cls = CLS_JUMP;
                if (hi_cnt < CNT_MAX) hi_cnt++;
            end
            else
            begin
                cls = CLS_STAND;
                hi_on = 0;
                hi_cnt = 0;
            end
        end
        else if (dm < WALK_LIMIT)
        begin
            if (hi_on && hi_cnt < HIGH_RUN)
            begin
                cls = CLS_JUMP;
                hi_cnt++;
            end
            else
            begin
                cls = CLS_WALK;
                hi_on = 0;
                hi_cnt = 0;
            end
        end
        else
        begin
            if (!hi_on)
            begin
                hi_on = 1;
                hi_cnt = 0;
            end
            else if (hi_cnt < CNT_MAX) hi_cnt++;
            if (hi_cnt > HIGH_RUN) cls = CLS_RUN;
        end
        r.cls = cls;
        r.dmag = dm[DMAG_W-1:0];
        for (int k = 0; k < 4; k++) r.sd[k] = STD_W'(window_sd(k));
        for (int i = 0; i < 3; i++) r.ang[i] = ang[i];
        sample_results.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        longint ax[3], gy[3];
        motion_result_t e, a;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_off[i] = 0;
                gyro_off[i] = 0;
                last_acc[i] = 0;
                last_gyro[i] = 0;
                ang[i] = '0;
            end
            for (int k = 0; k < 4; k++)
            begin
                wsum[k] = 0;
                wsq[k] = 0;
                for (int j = 0; j < DEPTH; j++) win[k][j] = 0;
            end
            gain = 64'(ANGLE_GAIN_RST);
            deadband = 64'(DEADBAND_RST);
            wp = 0;
            cls = CLS_NONE;
            hi_on = 0;
            hi_cnt = 0;
            fail_count = 0;
            sample_results.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_ACC_OFF_X, REG_ACC_OFF_Y, REG_ACC_OFF_Z:
                        acc_off[cfg_addr] = longint'($signed(cfg_wdata[ACC_W-1:0]));
                    REG_GYRO_OFF_X, REG_GYRO_OFF_Y, REG_GYRO_OFF_Z:
                        gyro_off[cfg_addr - REG_GYRO_OFF_X] = longint'($signed(cfg_wdata));
                    REG_ANGLE_GAIN: gain = 64'(cfg_wdata[GAIN_W-1:0]);
                    REG_DEADBAND: deadband = 64'(cfg_wdata[DB_W-1:0]);
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                a.cls = motion_class;
                a.dmag = diff_magnitude;
                a.sd = {std_magnitude, std_z, std_y, std_x};
                a.ang = {angle_z, angle_y, angle_x};
                if (sample_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", a);
                end
                else
                begin
                    e = sample_results.pop_front();
                    if (e !== a)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: cls %0d/%0d dmag %0d/%0d std %h/%h ang %h/%h",
                                     e.cls, a.cls, e.dmag, a.dmag, e.sd, a.sd, e.ang, a.ang);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                ax = '{acc_x, acc_y, acc_z};
                gy = '{gyro_x, gyro_y, gyro_z};
                predict_sample(ax, gy);
            end
            pending = sample_results.size();
        end
    end
endmodule

FILE: dv/imu_motion_activity_classifier_unit_test.sv
// Testbench top: stimulus, register settings, idling phases and verdict.
`timescale 1ns / 1ps
module imu_motion_activity_classifier_unit_test;
    import imac_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CFG_A_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic in_valid = 0, in_ready, out_valid, out_ready = 0;
    logic signed [ACC_W-1:0] acc_x = '0, acc_y = '0, acc_z = '0;
    logic signed [GYRO_W-1:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic [CLASS_W-1:0] motion_class;
    logic [DMAG_W-1:0] diff_magnitude;
    logic [STD_W-1:0] std_x, std_y, std_z, std_magnitude;
    logic signed [ANGLE_W-1:0] angle_x, angle_y, angle_z;
    int fail_count, pending;
    int send_idle = 0, recv_idle = 0;
    int quiet = 0;

    always #5 clk = ~clk;

    imu_motion_activity_classifier_unit dut (.*);
    imac_checker chk (.*);

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 0;
        @(posedge clk);
    endtask

    task automatic send_sample(logic [15:0] ax, ay, az, logic [21:0] gx, gy, gz);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        acc_x <= ax; acc_y <= ay; acc_z <= az;
        gyro_x <= gx; gyro_y <= gy; gyro_z <= gz;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic logic [21:0] rand_gyro();
        case ($urandom_range(3))
            0: return 22'($urandom_range(4000000)) - 22'd2000000;
            1: return 22'($urandom);
            2: return 22'($urandom_range(200)) - 22'd100;
            default: return $urandom_range(1) ? 22'h200000 : 22'h1FFFFF;
        endcase
    endfunction

    function automatic logic [15:0] rand_acc(int spread);
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(2 * spread) - spread + 1000);
    endfunction

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int spread;
        logic [15:0] b;
        for (int i = 0; i < n; i++)
        begin
            spread = ($urandom_range(2) == 0) ? 40 : ($urandom_range(1) ? 500 : 3000);
            b = rand_acc(spread);
            send_sample(b, rand_acc(spread), rand_acc(spread),
                        rand_gyro(), rand_gyro(), rand_gyro());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: extremes, then stand, walk, a high run, jumps after it
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 22'h1E8480, 22'h217B80, 22'h0);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 22'h217B80, 22'h1E8480, 22'h3FFFFF);
        send_sample(16'h0, 16'h0, 16'h0, 22'd50, 22'd51, -22'sd51);
        send_sample(16'h0, 16'h0, 16'h0, 22'd0, 22'd0, 22'd0);
        send_sample(16'd500, 16'h0, 16'h0, 22'd1000, 22'd0, 22'd0);
        for (int i = 0; i < 8; i++)
            send_sample((i % 2) ? 16'd3000 : -16'sd3000, 16'h0, 16'h0, 22'd5000, 0, 0);
        send_sample(-16'sd3000, 16'h0, 16'h0, 0, 0, 0);
        send_sample(-16'sd3000, 16'h0, 16'h0, 0, 0, 0);
        for (int i = 0; i < 3; i++) send_sample(16'd2000, 0, 0, 0, 0, 0);
        send_sample(16'd2500, 0, 0, 0, 0, 0);
        send_sample(16'd3000, 0, 0, 0, 0, 0);
        drain();

        write_reg(REG_ACC_OFF_X, 22'h8000);
        write_reg(REG_ACC_OFF_Y, 22'h7FFF);
        write_reg(REG_ACC_OFF_Z, 22'hFFFF);
        write_reg(REG_GYRO_OFF_X, 22'h1E8480);
        write_reg(REG_GYRO_OFF_Y, 22'h217B80);
        write_reg(REG_GYRO_OFF_Z, 22'h3FFFFF);
        write_reg(REG_ANGLE_GAIN, 22'hFFFF);
        write_reg(REG_DEADBAND, 22'd0);
        send_idle = 29;
        recv_idle = 69;
        random_phase(630);
        drain();

        write_reg(REG_ANGLE_GAIN, 22'd0);
        write_reg(REG_DEADBAND, 22'h1FFFFF);
        write_reg(REG_ACC_OFF_X, 22'd0);
        send_idle = 69;
        recv_idle = 29;
        random_phase(300);
        drain();

        for (int r = 0; r < 8; r++) write_reg(r[CFG_A_W-1:0], 22'($urandom));
        write_reg(REG_DEADBAND, 22'($urandom_range(3000)));
        random_phase(330);
        drain();

        write_reg(REG_ACC_OFF_X, 22'd0);
        write_reg(REG_ACC_OFF_Y, 22'd0);
        write_reg(REG_ACC_OFF_Z, 22'd0);
        write_reg(REG_GYRO_OFF_X, 22'd0);
        write_reg(REG_GYRO_OFF_Y, 22'd0);
        write_reg(REG_GYRO_OFF_Z, 22'd0);
        write_reg(REG_ANGLE_GAIN, 22'($urandom_range(65535)));
        write_reg(REG_DEADBAND, 22'd50);
        send_idle = 0;
        recv_idle = 0;
        random_phase(620);
        drain();

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
